// File: sv/rrcsh_pkg.sv
`default_nettype none

package rrcsh_pkg;

    // Field widths fixed by the item and register formats
    localparam int POS_W      = 20;
    localparam int HALF_W     = 19;
    localparam int TRIG_W     = 16;
    localparam int SIZE_W     = 16;
    localparam int BIN_W      = 7;
    localparam int OUT_CNT_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Datapath widths of the rotation
    localparam int DIFF_W = POS_W + 1;
    localparam int PROD_W = DIFF_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int FRAC_W = 14;

    // Defaults for the top level parameters
    localparam int DEFAULT_NUM_BINS    = 120;
    localparam int DEFAULT_COUNT_WIDTH = 32;

    // Reset value of the cosine register (1.0 in Q1.14)
    localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE   = 3'd5;

    // ROI geometry handed to the classifier
    typedef struct packed {
        logic signed [POS_W-1:0]  center_x;
        logic signed [POS_W-1:0]  center_y;
        logic        [HALF_W-1:0] half_width;
        logic        [HALF_W-1:0] half_height;
        logic signed [TRIG_W-1:0] cos_angle;
        logic signed [TRIG_W-1:0] sin_angle;
    } roi_cfg_t;

    // Stage load strobes for the classifier pipeline
    typedef struct packed {
        logic load_diff;
        logic load_prod;
    } roi_load_t;

endpackage

`default_nettype wire

// File: sv/rotated_roi_cluster_size_histogram_unit.sv
`default_nettype none

// Rotated-ROI cluster size histogram. Each mode-0 item is a cluster hit: its centroid is
// shifted by the ROI center and rotated by the cos/sin registers, and if it lies strictly
// inside the half extents, a size of 1..NUM_BINS bumps that bin (saturating). Mode-1 items
// read one bin. One item is accepted per cycle while s_ready is high; m_ready can stall the
// pipeline. An item passes offset (taken at acceptance), products, classify plus histogram
// read, and update; the histogram read-modify-write forwards the last write so back-to-back
// hits on one bin count correctly.
// After reset the histogram RAM is cleared one bin per cycle, during which s_ready stays low;
// configuration writes are taken throughout.
module rotated_roi_cluster_size_histogram_unit #(
    parameter int NUM_BINS    = rrcsh_pkg::DEFAULT_NUM_BINS,
    parameter int COUNT_WIDTH = rrcsh_pkg::DEFAULT_COUNT_WIDTH
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // configuration
    input  wire logic                                    cfg_wr_en,
    input  wire logic [rrcsh_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [rrcsh_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    // input items
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic                                    s_mode,
    input  wire logic signed [rrcsh_pkg::POS_W-1:0]      s_pos_x,
    input  wire logic signed [rrcsh_pkg::POS_W-1:0]      s_pos_y,
    input  wire logic [rrcsh_pkg::SIZE_W-1:0]            s_cluster_size,
    input  wire logic [rrcsh_pkg::BIN_W-1:0]             s_bin_index,
    // result items
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic                                         m_inside_res,
    output logic                                         m_size_out_of_range,
    output logic [rrcsh_pkg::OUT_CNT_W-1:0]              m_bin_count
);

    localparam int AW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CW  = COUNT_WIDTH;
    localparam int SZW = rrcsh_pkg::SIZE_W;
    localparam logic [SZW:0]   NB_LIMIT  = (SZW+1)'(NUM_BINS);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(NUM_BINS - 1);
    localparam logic [CW-1:0]  CMAX      = {CW{1'b1}};

    // Configuration registers
    rrcsh_pkg::roi_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x    <= '0;
            cfg_reg.center_y    <= '0;
            cfg_reg.half_width  <= '0;
            cfg_reg.half_height <= '0;
            cfg_reg.cos_angle   <= rrcsh_pkg::COS_RESET;
            cfg_reg.sin_angle   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rrcsh_pkg::CFG_CENTER_X:    cfg_reg.center_x    <= cfg_wr_data[19:0];
                rrcsh_pkg::CFG_CENTER_Y:    cfg_reg.center_y    <= cfg_wr_data[19:0];
                rrcsh_pkg::CFG_HALF_WIDTH:  cfg_reg.half_width  <= cfg_wr_data[18:0];
                rrcsh_pkg::CFG_HALF_HEIGHT: cfg_reg.half_height <= cfg_wr_data[18:0];
                rrcsh_pkg::CFG_COS_ANGLE:   cfg_reg.cos_angle   <= cfg_wr_data[15:0];
                rrcsh_pkg::CFG_SIN_ANGLE:   cfg_reg.sin_angle   <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Clearing pass over the histogram after reset
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // Pipeline handshake: each stage advances when the next one is empty or advancing
    logic a_valid_reg, b_valid_reg, c_valid_reg, m_valid_reg;
    logic a_ready, b_ready, c_ready, out_ready;
    logic s_fire, a_fire, b_fire, c_fire;

    assign out_ready = !m_valid_reg || m_ready;
    assign c_ready   = !c_valid_reg || out_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign s_ready   = a_ready && !clearing_reg;
    assign s_fire    = s_valid && s_ready;
    assign a_fire    = a_valid_reg && b_ready;
    assign b_fire    = b_valid_reg && c_ready;
    assign c_fire    = c_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_ready)   a_valid_reg <= s_fire;
            if (b_ready)   b_valid_reg <= a_fire;
            if (c_ready)   c_valid_reg <= b_fire;
            if (out_ready) m_valid_reg <= c_fire;
        end
    end

    // Bin selection and range check at the input
    logic [SZW-1:0] sel_bin;
    logic           sel_ok;
    logic [AW-1:0]  sel_addr;

    always_comb begin
        sel_bin  = s_mode ? SZW'(s_bin_index) : s_cluster_size;
        sel_ok   = (sel_bin != '0) && ((SZW+1)'(sel_bin) <= NB_LIMIT);
        sel_addr = sel_ok ? AW'(sel_bin - SZW'(1)) : '0;
    end

    // Control payload carried along the pipeline
    logic          a_mode_reg, b_mode_reg, c_mode_reg;
    logic          a_ok_reg, b_ok_reg, c_ok_reg;
    logic [AW-1:0] a_addr_reg, b_addr_reg, c_addr_reg;
    logic          c_inside_reg;
    logic          roi_inside;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_mode_reg <= s_mode;
            a_ok_reg   <= sel_ok;
            a_addr_reg <= sel_addr;
        end
        if (a_fire) begin
            b_mode_reg <= a_mode_reg;
            b_ok_reg   <= a_ok_reg;
            b_addr_reg <= a_addr_reg;
        end
        if (b_fire) begin
            c_mode_reg   <= b_mode_reg;
            c_ok_reg     <= b_ok_reg;
            c_addr_reg   <= b_addr_reg;
            c_inside_reg <= roi_inside;
        end
    end

    // ROI classifier
    rrcsh_pkg::roi_load_t roi_load;

    assign roi_load.load_diff = s_fire;
    assign roi_load.load_prod = a_fire;

    rrcsh_roi u_roi (
        .aclk   (aclk),
        .cfg    (cfg_reg),
        .load   (roi_load),
        .pos_x  (s_pos_x),
        .pos_y  (s_pos_y),
        .in_roi (roi_inside)
    );

    // Histogram memory: read as an item enters the update stage, write as it leaves
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [CW-1:0] ram_wr_data;
    logic [CW-1:0] ram_rd_data;

    rrcsh_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_BINS)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (b_fire),
        .rd_addr (b_addr_reg),
        .rd_data (ram_rd_data)
    );

    // Update stage: forward the last write, increment with saturation
    logic          last_wr_valid_reg;
    logic [AW-1:0] last_wr_addr_reg;
    logic [CW-1:0] last_wr_data_reg;
    logic [CW-1:0] old_count, new_count;
    logic          hit_count, do_write;

    always_comb begin
        old_count = (last_wr_valid_reg && last_wr_addr_reg == c_addr_reg)
                    ? last_wr_data_reg : ram_rd_data;
        new_count = (old_count == CMAX) ? old_count : old_count + CW'(1);
        hit_count = !c_mode_reg && c_inside_reg && c_ok_reg;
        do_write  = c_fire && hit_count;
        if (clearing_reg) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = do_write;
            ram_wr_addr = c_addr_reg;
            ram_wr_data = new_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_wr_valid_reg <= 1'b0;
        end else if (do_write) begin
            last_wr_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            last_wr_addr_reg <= c_addr_reg;
            last_wr_data_reg <= new_count;
        end
    end

    // Result register
    logic                             res_inside_reg, res_oor_reg;
    logic [rrcsh_pkg::OUT_CNT_W-1:0]  res_count_reg;
    logic [CW-1:0]                    res_count_full;
    logic [63:0]                      res_count_wide;

    always_comb begin
        if (hit_count) begin
            res_count_full = new_count;
        end else if (c_mode_reg && c_ok_reg) begin
            res_count_full = old_count;
        end else begin
            res_count_full = '0;
        end
        res_count_wide = 64'(res_count_full);
    end

    always_ff @(posedge aclk) begin
        if (c_fire) begin
            res_inside_reg <= !c_mode_reg && c_inside_reg;
            res_oor_reg    <= !c_mode_reg && c_inside_reg && !c_ok_reg;
            res_count_reg  <= res_count_wide[rrcsh_pkg::OUT_CNT_W-1:0];
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_inside_res        = res_inside_reg;
    assign m_size_out_of_range = res_oor_reg;
    assign m_bin_count         = res_count_reg;

endmodule

`default_nettype wire

// File: sv/rrcsh_ram.sv
`default_nettype none

module rrcsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 120,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; a read at the write address returns the old data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/rrcsh_roi.sv
`default_nettype none

module rrcsh_roi (
    input  wire logic                               aclk,
    input  wire rrcsh_pkg::roi_cfg_t                cfg,
    input  wire rrcsh_pkg::roi_load_t               load,
    input  wire logic signed [rrcsh_pkg::POS_W-1:0] pos_x,
    input  wire logic signed [rrcsh_pkg::POS_W-1:0] pos_y,
    output logic                                    in_roi
);

    localparam int DW = rrcsh_pkg::DIFF_W;
    localparam int PW = rrcsh_pkg::PROD_W;
    localparam int SW = rrcsh_pkg::SUM_W;

    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [PW-1:0] xc_reg, ys_reg, yc_reg, xs_reg;
    logic signed [SW-1:0] u, v;
    logic        [SW-1:0] u_mag, v_mag, u_lim, v_lim;

    // Offset from the ROI center
    always_ff @(posedge aclk) begin
        if (load.load_diff) begin
            dx_reg <= DW'(pos_x) - DW'(cfg.center_x);
            dy_reg <= DW'(pos_y) - DW'(cfg.center_y);
        end
    end

    // Rotation products
    always_ff @(posedge aclk) begin
        if (load.load_prod) begin
            xc_reg <= PW'(dx_reg) * PW'(cfg.cos_angle);
            ys_reg <= PW'(dy_reg) * PW'(cfg.sin_angle);
            yc_reg <= PW'(dy_reg) * PW'(cfg.cos_angle);
            xs_reg <= PW'(dx_reg) * PW'(cfg.sin_angle);
        end
    end

    // Rotate, take magnitudes and compare strictly against the scaled half extents
    always_comb begin
        u     = SW'(xc_reg) + SW'(ys_reg);
        v     = SW'(yc_reg) - SW'(xs_reg);
        u_mag = u[SW-1] ? SW'(-u) : SW'(u);
        v_mag = v[SW-1] ? SW'(-v) : SW'(v);
        u_lim = SW'({cfg.half_width, {rrcsh_pkg::FRAC_W{1'b0}}});
        v_lim = SW'({cfg.half_height, {rrcsh_pkg::FRAC_W{1'b0}}});
        in_roi = (u_mag < u_lim) && (v_mag < v_lim);
    end

endmodule

`default_nettype wire
